// ===== design/cbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbfs_pkg
// Shared codes, widths and handshake structs for the cube basis-function
// screen: command and shell codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cbfs_pkg;

  // Field widths
  localparam int DIST_W  = 50;
  localparam int COUNT_W = 13;

  // Largest representable squared distance
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Function indexes at or above this are ignored
  localparam int MAX_FUNCS = 4096;

  // Command codes
  localparam logic [1:0] CMD_ATOM  = 2'd0;
  localparam logic [1:0] CMD_FUNC  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Shell kinds
  localparam logic [1:0] KIND_S    = 2'd0;
  localparam logic [1:0] KIND_P    = 2'd1;
  localparam logic [1:0] KIND_D    = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_EDGE     = 3'd3;
  localparam logic [2:0] REG_LIMIT    = 3'd4;
  localparam logic [2:0] REG_KEEP_ALL = 3'd5;

  // Configuration reset values
  localparam logic [22:0] EDGE_RST  = 23'd4096;
  localparam logic [31:0] LIMIT_RST = 32'd655360;

  // Request from the last stage to the count and mark keeper
  typedef struct packed {
    logic       fire;
    logic       clear;
    logic       keep;
    logic [1:0] kind;
    logic       inrange;
    logic [7:0] owner;
  } tally_req_t;

  // Counts after the item, and whether its nucleus was unmarked
  typedef struct packed {
    logic               fresh;
    logic [COUNT_W-1:0] s_total;
    logic [COUNT_W-1:0] p_total;
    logic [COUNT_W-1:0] d_total;
  } tally_rsp_t;

endpackage

`default_nettype wire

// ===== design/cbfs_axis.sv =====
// ----------------------------------------------------------------------------
// cbfs_axis
// One axis of the cube distance: gap of the nucleus outside the cube
// interval, registered, then squared and registered again.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfs_axis (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic signed [23:0] origin,
  input  wire logic        [22:0] cube_edge,
  input  wire logic signed [23:0] pos,
  output logic             [47:0] sq
);

  logic signed [25:0] lo;
  logic signed [25:0] hi;
  logic signed [25:0] p;
  logic signed [25:0] below;
  logic signed [25:0] above;
  logic        [23:0] gap_nxt;
  logic        [23:0] gap_r;
  logic        [47:0] sq_r;

  // Interval [origin, origin + edge] and the nucleus; origin and nucleus sign extended, edge zero extended
  assign lo    = {{2{origin[23]}}, origin};
  assign hi    = lo + $signed({3'b000, cube_edge});
  assign p     = {{2{pos[23]}}, pos};
  assign below = lo - p;
  assign above = p - hi;

  // Distance outside the interval, zero when inside
  always_comb begin
    priority if (p < lo) begin
      gap_nxt = below[23:0];
    end else if (p > hi) begin
      gap_nxt = above[23:0];
    end else begin
      gap_nxt = '0;
    end
  end

  // Register the gap, then its square
  always_ff @(posedge clk) begin
    if (adv) begin
      gap_r <= gap_nxt;
      sq_r  <= 48'(gap_r) * 48'(gap_r);
    end
  end

  assign sq = sq_r;

endmodule

`default_nettype wire

// ===== design/cbfs_dist_ram.sv =====
// ----------------------------------------------------------------------------
// cbfs_dist_ram
// Per-atom squared distance store. One write port from the atom stage, one
// registered read port for function items, with a bypass of the write that
// lands in the same cycle as the read.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfs_dist_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic [7:0]                  rd_owner,
  input  wire logic                        wr_en,
  input  wire logic [7:0]                  wr_owner,
  input  wire logic [cbfs_pkg::DIST_W-1:0] wr_data,
  output logic      [cbfs_pkg::DIST_W-1:0] rd_data
);

  logic [cbfs_pkg::DIST_W-1:0] mem [DEPTH];
  logic [AW+7:0]               rd_wide;
  logic [AW+7:0]               wr_wide;
  logic [AW-1:0]               rd_idx;
  logic [AW-1:0]               wr_idx;
  logic [cbfs_pkg::DIST_W-1:0] rd_r;
  logic [cbfs_pkg::DIST_W-1:0] byp_data_r;
  logic                        byp_r;

  // Fit the 8-bit atom number to the address width
  assign rd_wide = {{AW{1'b0}}, rd_owner};
  assign wr_wide = {{AW{1'b0}}, wr_owner};
  assign rd_idx  = rd_wide[AW-1:0];
  assign wr_idx  = wr_wide[AW-1:0];

  // Write the atom distance
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Read, and catch a write to the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r       <= mem[rd_idx];
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (adv) begin
      byp_r <= wr_en && (wr_owner == rd_owner);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_r;

endmodule

`default_nettype wire

// ===== design/cbfs_screen.sv =====
// ----------------------------------------------------------------------------
// cbfs_screen
// Exact screen test: exponent times squared distance against the limit
// scaled to the same fraction bits. The 32 x 50 product is taken as two
// registered 32 x 25 halves and joined in the next stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfs_screen (
  input  wire logic                        clk,
  input  wire logic                        adv,
  input  wire logic [31:0]                 expo,
  input  wire logic [cbfs_pkg::DIST_W-1:0] dsq,
  input  wire logic [31:0]                 limit,
  output logic                             pass
);

  logic [56:0] lo_pp_r;
  logic [56:0] hi_pp_r;
  logic [81:0] product;
  logic [81:0] bound;

  // Partial products over the low and high halves of the distance
  always_ff @(posedge clk) begin
    if (adv) begin
      lo_pp_r <= 57'(expo) * 57'(dsq[24:0]);
      hi_pp_r <= 57'(expo) * 57'(dsq[49:25]);
    end
  end

  // Join the halves and compare, strictly below
  assign product = {hi_pp_r, 25'b0} + {25'b0, lo_pp_r};
  assign bound   = {26'b0, limit, 24'b0};
  assign pass    = product < bound;

endmodule

`default_nettype wire

// ===== design/cbfs_tally.sv =====
// ----------------------------------------------------------------------------
// cbfs_tally
// Kept-group counts per shell kind and the per-nucleus marks. Reports the
// counts after the current item and whether its nucleus is newly marked.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfs_tally #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cbfs_pkg::tally_req_t req,
  output cbfs_pkg::tally_rsp_t      rsp
);

  logic [cbfs_pkg::COUNT_W-1:0] s_r;
  logic [cbfs_pkg::COUNT_W-1:0] p_r;
  logic [cbfs_pkg::COUNT_W-1:0] d_r;
  logic [cbfs_pkg::COUNT_W-1:0] s_nxt;
  logic [cbfs_pkg::COUNT_W-1:0] p_nxt;
  logic [cbfs_pkg::COUNT_W-1:0] d_nxt;
  logic [DEPTH-1:0]             marks_r;
  logic [AW+7:0]                idx_wide;
  logic [AW-1:0]                idx;
  logic                         fresh;

  // Saturating increment
  function automatic logic [cbfs_pkg::COUNT_W-1:0] bump(
    input logic [cbfs_pkg::COUNT_W-1:0] c
  );
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign idx_wide = {{AW{1'b0}}, req.owner};
  assign idx      = idx_wide[AW-1:0];

  // Counts after this item
  always_comb begin
    s_nxt = s_r;
    p_nxt = p_r;
    d_nxt = d_r;
    if (req.clear) begin
      s_nxt = '0;
      p_nxt = '0;
      d_nxt = '0;
    end else if (req.keep) begin
      unique case (req.kind)
        cbfs_pkg::KIND_S: s_nxt = bump(s_r);
        cbfs_pkg::KIND_P: p_nxt = bump(p_r);
        cbfs_pkg::KIND_D: d_nxt = bump(d_r);
        default: ;
      endcase
    end
  end

  assign fresh = req.keep && req.inrange && !marks_r[idx];

  // Commit counts and marks when the item leaves the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r     <= '0;
      p_r     <= '0;
      d_r     <= '0;
      marks_r <= '0;
    end else if (req.fire) begin
      s_r <= s_nxt;
      p_r <= p_nxt;
      d_r <= d_nxt;
      if (req.clear) begin
        marks_r <= '0;
      end else if (req.keep && req.inrange) begin
        marks_r[idx] <= 1'b1;
      end
    end
  end

  assign rsp.fresh   = fresh;
  assign rsp.s_total = s_nxt;
  assign rsp.p_total = p_nxt;
  assign rsp.d_total = d_nxt;

endmodule

`default_nettype wire

// ===== design/cube_basis_function_screen_unit.sv =====
// ----------------------------------------------------------------------------
// cube_basis_function_screen_unit
// Screens basis-function groups against one cube of a quadrature grid.
//
// Input channel (in_valid / in_stall): one beat per item. An atom beat
// stores the squared nucleus-to-cube distance for its slot; a function beat
// screens one group against its nucleus distance and the exponent limit; a
// clear beat zeroes the kind counts and the nucleus marks.
// Result channel (out_valid / out_stall): exactly one result beat per item,
// in order. Configuration channel (cfg_valid / cfg_ready): cfg_index selects
// the register, cfg_data carries the value; ready is always high. Write it
// only while no item is in flight.
// The block takes one beat per cycle while in_stall is low. Four pipeline
// stages (gap, square and table read, sum and partial products, product
// compare and tally) feed an output register; a table write in the read
// cycle is bypassed.
// Reset: counts, nucleus marks, valids and registers return to their reset
// values; the distance table keeps whatever it held and must be written by
// an atom beat before a function beat reads that slot.
// Stall: while out_stall holds a result, the pipeline still moves as long as
// its last stage is empty; once it is occupied, in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_basis_function_screen_unit #(
  parameter int MAX_ATOMS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_atom_slot,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic signed [23:0] in_pos_z,
  input  wire logic [11:0] in_func_id,
  input  wire logic [1:0]  in_shell_kind,
  input  wire logic [7:0]  in_owner_atom,
  input  wire logic [31:0] in_min_exponent,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kept,
  output logic [11:0]      out_func_id_out,
  output logic [7:0]       out_owner_out,
  output logic             out_nucleus_new,
  output logic [49:0]      out_dist_sq,
  output logic [12:0]      out_s_total,
  output logic [12:0]      out_p_total,
  output logic [12:0]      out_d_total,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int Depth = (MAX_ATOMS < 256) ? MAX_ATOMS : 256;
  localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;

  // Configuration registers
  logic signed [23:0] origin_x_r;
  logic signed [23:0] origin_y_r;
  logic signed [23:0] origin_z_r;
  logic        [22:0] edge_r;
  logic        [31:0] limit_r;
  logic               keep_all_r;

  // Pipeline control
  logic adv;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic out_valid_r;

  // Input selection
  logic [7:0]  owner_nxt;
  logic [11:0] fid_nxt;
  logic        inrange_nxt;

  // Stage payload
  logic [1:0]  s1_cmd_r, s2_cmd_r, s3_cmd_r, s4_cmd_r;
  logic [7:0]  s1_owner_r, s2_owner_r, s3_owner_r, s4_owner_r;
  logic [11:0] s1_fid_r, s2_fid_r, s3_fid_r, s4_fid_r;
  logic [1:0]  s1_kind_r, s2_kind_r, s3_kind_r, s4_kind_r;
  logic [31:0] s1_expo_r, s2_expo_r, s3_expo_r;
  logic        s1_inrange_r, s2_inrange_r, s3_inrange_r, s4_inrange_r;
  logic signed [23:0] s1_pos_x_r, s1_pos_y_r, s1_pos_z_r;
  logic [cbfs_pkg::DIST_W-1:0] s4_dist_r;

  // Stage three and four logic
  logic [47:0] sq_x, sq_y, sq_z;
  logic [50:0] sum3;
  logic [cbfs_pkg::DIST_W-1:0] atom_dist;
  logic [cbfs_pkg::DIST_W-1:0] ram_rd;
  logic [cbfs_pkg::DIST_W-1:0] fn_dist;
  logic [cbfs_pkg::DIST_W-1:0] dist_s3;
  logic        wr_en;
  logic        pass;
  logic        keep;
  cbfs_pkg::tally_req_t tally_req;
  cbfs_pkg::tally_rsp_t tally_rsp;

  // Output payload
  logic        out_kept_r;
  logic [11:0] out_fid_r;
  logic [7:0]  out_owner_r;
  logic        out_new_r;
  logic [49:0] out_dist_r;
  logic [12:0] out_s_r, out_p_r, out_d_r;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      edge_r     <= cbfs_pkg::EDGE_RST;
      limit_r    <= cbfs_pkg::LIMIT_RST;
      keep_all_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cbfs_pkg::REG_ORIGIN_X: origin_x_r <= cfg_data[23:0];
        cbfs_pkg::REG_ORIGIN_Y: origin_y_r <= cfg_data[23:0];
        cbfs_pkg::REG_ORIGIN_Z: origin_z_r <= cfg_data[23:0];
        cbfs_pkg::REG_EDGE:     edge_r     <= cfg_data[22:0];
        cbfs_pkg::REG_LIMIT:    limit_r    <= cfg_data;
        cbfs_pkg::REG_KEEP_ALL: keep_all_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance unless a held result would be overwritten
  assign adv      = !s4_v_r || !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // Pick the nucleus and function index that the result echoes
  always_comb begin
    owner_nxt = '0;
    fid_nxt   = '0;
    unique case (in_cmd)
      cbfs_pkg::CMD_ATOM: owner_nxt = in_atom_slot;
      cbfs_pkg::CMD_FUNC: begin
        owner_nxt = in_owner_atom;
        fid_nxt   = in_func_id;
      end
      default: ;
    endcase
  end

  assign inrange_nxt = {5'b0, owner_nxt} < 13'(MAX_ATOMS);

  // Stage payload shift
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r     <= in_cmd;
      s1_owner_r   <= owner_nxt;
      s1_fid_r     <= fid_nxt;
      s1_kind_r    <= in_shell_kind;
      s1_expo_r    <= in_min_exponent;
      s1_inrange_r <= inrange_nxt;
      s1_pos_x_r   <= in_pos_x;
      s1_pos_y_r   <= in_pos_y;
      s1_pos_z_r   <= in_pos_z;

      s2_cmd_r     <= s1_cmd_r;
      s2_owner_r   <= s1_owner_r;
      s2_fid_r     <= s1_fid_r;
      s2_kind_r    <= s1_kind_r;
      s2_expo_r    <= s1_expo_r;
      s2_inrange_r <= s1_inrange_r;

      s3_cmd_r     <= s2_cmd_r;
      s3_owner_r   <= s2_owner_r;
      s3_fid_r     <= s2_fid_r;
      s3_kind_r    <= s2_kind_r;
      s3_expo_r    <= s2_expo_r;
      s3_inrange_r <= s2_inrange_r;

      s4_cmd_r     <= s3_cmd_r;
      s4_owner_r   <= s3_owner_r;
      s4_fid_r     <= s3_fid_r;
      s4_kind_r    <= s3_kind_r;
      s4_inrange_r <= s3_inrange_r;
      s4_dist_r    <= dist_s3;
    end
  end

  // Per-axis gap and square
  cbfs_axis u_axis_x (
    .clk       (clk),
    .adv       (adv),
    .origin    (origin_x_r),
    .cube_edge (edge_r),
    .pos       (s1_pos_x_r),
    .sq        (sq_x)
  );

  cbfs_axis u_axis_y (
    .clk       (clk),
    .adv       (adv),
    .origin    (origin_y_r),
    .cube_edge (edge_r),
    .pos       (s1_pos_y_r),
    .sq        (sq_y)
  );

  cbfs_axis u_axis_z (
    .clk       (clk),
    .adv       (adv),
    .origin    (origin_z_r),
    .cube_edge (edge_r),
    .pos       (s1_pos_z_r),
    .sq        (sq_z)
  );

  // Sum the squares, saturate
  assign sum3      = {3'b0, sq_x} + {3'b0, sq_y} + {3'b0, sq_z};
  assign atom_dist = sum3[50] ? cbfs_pkg::DIST_MAX : sum3[49:0];

  // Store atom distances; function items read in stage two
  assign wr_en = adv && s3_v_r && (s3_cmd_r == cbfs_pkg::CMD_ATOM) && s3_inrange_r;

  cbfs_dist_ram #(
    .DEPTH (Depth),
    .AW    (Aw)
  ) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .rd_owner (s2_owner_r),
    .wr_en    (wr_en),
    .wr_owner (s3_owner_r),
    .wr_data  (atom_dist),
    .rd_data  (ram_rd)
  );

  assign fn_dist = s3_inrange_r ? ram_rd : '0;

  // Distance the result reports
  always_comb begin
    unique case (s3_cmd_r)
      cbfs_pkg::CMD_ATOM: dist_s3 = atom_dist;
      cbfs_pkg::CMD_FUNC: dist_s3 = fn_dist;
      default:            dist_s3 = '0;
    endcase
  end

  // Screen test over stages three and four
  cbfs_screen u_screen (
    .clk   (clk),
    .adv   (adv),
    .expo  (s3_expo_r),
    .dsq   (fn_dist),
    .limit (limit_r),
    .pass  (pass)
  );

  // Keep decision and tally
  assign keep = (s4_cmd_r == cbfs_pkg::CMD_FUNC) &&
                (s4_kind_r != cbfs_pkg::KIND_NONE) &&
                ({5'b0, s4_fid_r} < 17'(cbfs_pkg::MAX_FUNCS)) &&
                (keep_all_r || pass);

  assign tally_req.fire    = adv && s4_v_r;
  assign tally_req.clear   = (s4_cmd_r == cbfs_pkg::CMD_CLEAR);
  assign tally_req.keep    = keep;
  assign tally_req.kind    = s4_kind_r;
  assign tally_req.inrange = s4_inrange_r;
  assign tally_req.owner   = s4_owner_r;

  cbfs_tally #(
    .DEPTH (Depth),
    .AW    (Aw)
  ) u_tally (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tally_req),
    .rsp   (tally_rsp)
  );

  // Output register: load on a finished item, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s4_v_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_v_r) begin
      out_kept_r  <= keep;
      out_fid_r   <= s4_fid_r;
      out_owner_r <= s4_owner_r;
      out_new_r   <= tally_rsp.fresh;
      out_dist_r  <= s4_dist_r;
      out_s_r     <= tally_rsp.s_total;
      out_p_r     <= tally_rsp.p_total;
      out_d_r     <= tally_rsp.d_total;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kept        = out_kept_r;
  assign out_func_id_out = out_fid_r;
  assign out_owner_out   = out_owner_r;
  assign out_nucleus_new = out_new_r;
  assign out_dist_sq     = out_dist_r;
  assign out_s_total     = out_s_r;
  assign out_p_total     = out_p_r;
  assign out_d_total     = out_d_r;

`ifndef NO_ASSERTIONS
  // A clear item leaves all counts at zero in its result
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s4_v_r && (s4_cmd_r == cbfs_pkg::CMD_CLEAR)) |=>
      (out_s_total == '0 && out_p_total == '0 && out_d_total == '0))
    else $error("counts not zero after clear");

  // A nucleus is only reported new for a kept group
  a_new_needs_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kept_r || !out_new_r))
    else $error("nucleus_new without kept");

  // Only function items can be kept
  a_kept_is_func: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s4_v_r && (s4_cmd_r != cbfs_pkg::CMD_FUNC)) |=>
      (!out_kept_r && out_func_id_out == '0))
    else $error("non-function item kept");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cube_basis_function_screen_unit. A directed table
// covers the coordinate and exponent extremes, the exact screen boundary,
// the ignored shell kind, the spare command and a clear. Random phases then
// stream atom and function beats under several cube settings, one of them
// back to back. Each result beat is compared field by field with an
// in-order queue filled by a cycle-free model of the screen.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIST_W  = cbfs_pkg::DIST_W;
  localparam int COUNT_W = cbfs_pkg::COUNT_W;

  // Spare command: no effect on state
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [COUNT_W-1:0] TALLY_MAX = '1;
  localparam int PHASE_ITEMS = 142;
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  slot;
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] pz;
    logic [11:0] fid;
    logic [1:0]  kind;
    logic [7:0]  owner;
    logic [31:0] expo;
  } screen_item_t;

  typedef struct packed {
    logic               kept;
    logic [11:0]        fid;
    logic [7:0]         owner;
    logic               fresh;
    logic [DIST_W-1:0]  dsq;
    logic [COUNT_W-1:0] s_total;
    logic [COUNT_W-1:0] p_total;
    logic [COUNT_W-1:0] d_total;
  } screen_res_t;

  typedef struct packed {
    logic [23:0] ox;
    logic [23:0] oy;
    logic [23:0] oz;
    logic [22:0] len;
    logic [31:0] limit;
    logic        keep;
  } cube_cfg_t;

  typedef struct {
    screen_item_t item;
    bit           fixed;
    screen_res_t  want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [7:0]  in_atom_slot;
  logic [23:0] in_pos_x;
  logic [23:0] in_pos_y;
  logic [23:0] in_pos_z;
  logic [11:0] in_func_id;
  logic [1:0]  in_shell_kind;
  logic [7:0]  in_owner_atom;
  logic [31:0] in_min_exponent;
  logic        out_valid;
  logic        out_stall;
  logic        out_kept;
  logic [11:0] out_func_id_out;
  logic [7:0]  out_owner_out;
  logic        out_nucleus_new;
  logic [49:0] out_dist_sq;
  logic [12:0] out_s_total;
  logic [12:0] out_p_total;
  logic [12:0] out_d_total;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Model copy of the registers
  logic [23:0] cfg_ox;
  logic [23:0] cfg_oy;
  logic [23:0] cfg_oz;
  logic [22:0] cfg_len;
  logic [31:0] cfg_limit;
  logic        cfg_keep;

  // Model copy of the distance store, nucleus marks and kind counts
  logic [DIST_W-1:0]  dist_store [256];
  bit                 slot_known [256];
  logic [7:0]         known_slots [$];
  bit                 marks [256];
  logic [COUNT_W-1:0] tally_s;
  logic [COUNT_W-1:0] tally_p;
  logic [COUNT_W-1:0] tally_d;

  screen_res_t   pending_results [$];
  directed_row_t directed_rows [$];

  bit          idle_on;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned kept_seen;
  int unsigned reg_writes;
  int unsigned settings_used;
  int unsigned quiet_cycles;

  always #5 clk = ~clk;

  cube_basis_function_screen_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_atom_slot    (in_atom_slot),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_func_id      (in_func_id),
    .in_shell_kind   (in_shell_kind),
    .in_owner_atom   (in_owner_atom),
    .in_min_exponent (in_min_exponent),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kept        (out_kept),
    .out_func_id_out (out_func_id_out),
    .out_owner_out   (out_owner_out),
    .out_nucleus_new (out_nucleus_new),
    .out_dist_sq     (out_dist_sq),
    .out_s_total     (out_s_total),
    .out_p_total     (out_p_total),
    .out_d_total     (out_d_total),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // ---------------------------------------------------------------- model

  // Distance outside [origin, origin + edge] on one axis
  function automatic longint axis_gap(logic [23:0] origin, logic [23:0] pos);
    longint lo;
    longint hi;
    longint p;
    lo = longint'($signed(origin));
    hi = lo + longint'(cfg_len);
    p  = longint'($signed(pos));
    if (p < lo) return lo - p;
    if (p > hi) return p - hi;
    return 0;
  endfunction

  function automatic logic [DIST_W-1:0] cube_dist(screen_item_t it);
    longint gx;
    longint gy;
    longint gz;
    longint sum;
    gx = axis_gap(cfg_ox, it.px);
    gy = axis_gap(cfg_oy, it.py);
    gz = axis_gap(cfg_oz, it.pz);
    sum = gx * gx + gy * gy + gz * gz;
    if (sum > longint'(cbfs_pkg::DIST_MAX)) return cbfs_pkg::DIST_MAX;
    return sum[DIST_W-1:0];
  endfunction

  // Exact product against the threshold, strictly below
  function automatic bit screen_pass(logic [31:0] expo, logic [DIST_W-1:0] dsq);
    logic [81:0] prod;
    logic [81:0] bound;
    prod  = 82'(expo) * 82'(dsq);
    bound = 82'(cfg_limit) << 24;
    return prod < bound;
  endfunction

  function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
    return (c == TALLY_MAX) ? c : c + 1'b1;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      cbfs_pkg::REG_ORIGIN_X: cfg_ox = data[23:0];
      cbfs_pkg::REG_ORIGIN_Y: cfg_oy = data[23:0];
      cbfs_pkg::REG_ORIGIN_Z: cfg_oz = data[23:0];
      cbfs_pkg::REG_EDGE:     cfg_len = data[22:0];
      cbfs_pkg::REG_LIMIT:    cfg_limit = data;
      cbfs_pkg::REG_KEEP_ALL: cfg_keep = data[0];
      default: ;
    endcase
  endfunction

  // Advance the model by one accepted item and return its result beat
  function automatic screen_res_t screen_predict(screen_item_t it);
    screen_res_t r;
    r = '0;
    case (it.cmd)
      cbfs_pkg::CMD_ATOM: begin
        r.owner = it.slot;
        r.dsq = cube_dist(it);
        dist_store[it.slot] = r.dsq;
        if (!slot_known[it.slot]) begin
          slot_known[it.slot] = 1'b1;
          known_slots.push_back(it.slot);
        end
      end
      cbfs_pkg::CMD_FUNC: begin
        r.fid = it.fid;
        r.owner = it.owner;
        r.dsq = dist_store[it.owner];
        if (it.kind != cbfs_pkg::KIND_NONE &&
            (cfg_keep || screen_pass(it.expo, r.dsq))) begin
          r.kept = 1'b1;
          case (it.kind)
            cbfs_pkg::KIND_S: tally_s = bump(tally_s);
            cbfs_pkg::KIND_P: tally_p = bump(tally_p);
            default: tally_d = bump(tally_d);
          endcase
          r.fresh = !marks[it.owner];
          marks[it.owner] = 1'b1;
        end
      end
      cbfs_pkg::CMD_CLEAR: begin
        tally_s = '0;
        tally_p = '0;
        tally_d = '0;
        foreach (marks[i]) marks[i] = 1'b0;
      end
      default: ;
    endcase
    r.s_total = tally_s;
    r.p_total = tally_p;
    r.d_total = tally_d;
    return r;
  endfunction

  // ------------------------------------------------------- item builders

  function automatic screen_item_t mk_atom(logic [7:0] slot, logic [23:0] x,
                                           logic [23:0] y, logic [23:0] z);
    screen_item_t it;
    it = '0;
    it.cmd = cbfs_pkg::CMD_ATOM;
    it.slot = slot;
    it.px = x;
    it.py = y;
    it.pz = z;
    return it;
  endfunction

  function automatic screen_item_t mk_func(logic [11:0] fid, logic [1:0] kind,
                                           logic [7:0] owner, logic [31:0] expo);
    screen_item_t it;
    it = '0;
    it.cmd = cbfs_pkg::CMD_FUNC;
    it.fid = fid;
    it.kind = kind;
    it.owner = owner;
    it.expo = expo;
    return it;
  endfunction

  function automatic screen_item_t mk_other(logic [1:0] cmd);
    screen_item_t it;
    it = '0;
    it.cmd = cmd;
    return it;
  endfunction

  function automatic screen_res_t mk_res(int kept, int fid, int owner, int fresh,
                                         int dsq, int s, int p, int d);
    screen_res_t r;
    r.kept = 1'(kept);
    r.fid = 12'(fid);
    r.owner = 8'(owner);
    r.fresh = 1'(fresh);
    r.dsq = DIST_W'(dsq);
    r.s_total = COUNT_W'(s);
    r.p_total = COUNT_W'(p);
    r.d_total = COUNT_W'(d);
    return r;
  endfunction

  function automatic logic [7:0] pick_owner();
    return known_slots[$urandom_range(0, known_slots.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Coordinate near the cube on one axis, or anywhere now and then
  function automatic logic [23:0] near_axis(logic [23:0] origin);
    int span;
    int v;
    if ($urandom_range(0, 4) == 0) return 24'($urandom);
    span = 1 << $urandom_range(0, 22);
    v = int'($signed(origin)) + int'($urandom_range(0, cfg_len))
        + int'($urandom_range(0, 2 * span)) - span;
    return v[23:0];
  endfunction

  // Mostly atoms and screenable functions; clears and dead beats as noise
  function automatic screen_item_t random_item();
    screen_item_t it;
    logic [159:0] noise;
    int unsigned r;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(screen_item_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < 30) begin
      it.cmd = cbfs_pkg::CMD_ATOM;
      it.px = near_axis(cfg_ox);
      it.py = near_axis(cfg_oy);
      it.pz = near_axis(cfg_oz);
    end else if (r < 88) begin
      it.cmd = cbfs_pkg::CMD_FUNC;
      it.kind = ($urandom_range(0, 9) == 0) ? cbfs_pkg::KIND_NONE
                                             : 2'($urandom_range(0, 2));
      it.owner = pick_owner();
      it.expo = pick_exponent();
    end else if (r < 94) begin
      it.cmd = cbfs_pkg::CMD_CLEAR;
    end else begin
      it.cmd = CMD_SPARE;
    end
    return it;
  endfunction

  function automatic cube_cfg_t random_cube();
    cube_cfg_t c;
    c.ox = 24'($urandom);
    c.oy = 24'($urandom);
    c.oz = 24'($urandom);
    c.len = 23'($urandom >> $urandom_range(9, 31));
    c.limit = $urandom >> $urandom_range(0, 31);
    c.keep = ($urandom_range(0, 3) == 0);
    return c;
  endfunction

  // -------------------------------------------------------------- drivers

  // Present one beat, hold it until taken, queue its expected result
  task automatic send_item(screen_item_t it, bit fixed, screen_res_t want);
    int unsigned gap;
    screen_res_t r;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= it.cmd;
    in_atom_slot    <= it.slot;
    in_pos_x        <= it.px;
    in_pos_y        <= it.py;
    in_pos_z        <= it.pz;
    in_func_id      <= it.fid;
    in_shell_kind   <= it.kind;
    in_owner_atom   <= it.owner;
    in_min_exponent <= it.expo;
    do @(posedge clk); while (in_stall);
    r = screen_predict(it);
    pending_results.push_back(fixed ? want : r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
  endtask

  // Drain the pipeline, then rewrite every register
  task automatic program_cube(cube_cfg_t c);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_write(cbfs_pkg::REG_ORIGIN_X, {{8{c.ox[23]}}, c.ox});
    cfg_write(cbfs_pkg::REG_ORIGIN_Y, {{8{c.oy[23]}}, c.oy});
    cfg_write(cbfs_pkg::REG_ORIGIN_Z, {{8{c.oz[23]}}, c.oz});
    cfg_write(cbfs_pkg::REG_EDGE, {9'd0, c.len});
    cfg_write(cbfs_pkg::REG_LIMIT, c.limit);
    cfg_write(cbfs_pkg::REG_KEEP_ALL, {31'd0, c.keep});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(int n);
    repeat (n) send_item(random_item(), 1'b0, '0);
  endtask

  // Result side: stall for a drawn number of cycles, then take one beat
  initial begin
    int unsigned gap;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // ------------------------------------------------------------- checking

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                              results_checked, name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    screen_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending, owner 0x%0h",
                                out_owner_out));
      end else begin
        want = pending_results.pop_front();
        check_field("kept", 64'(out_kept), 64'(want.kept));
        check_field("func_id", 64'(out_func_id_out), 64'(want.fid));
        check_field("owner", 64'(out_owner_out), 64'(want.owner));
        check_field("nucleus_new", 64'(out_nucleus_new), 64'(want.fresh));
        check_field("dist_sq", 64'(out_dist_sq), 64'(want.dsq));
        check_field("s_total", 64'(out_s_total), 64'(want.s_total));
        check_field("p_total", 64'(out_p_total), 64'(want.p_total));
        check_field("d_total", 64'(out_d_total), 64'(want.d_total));
        if (want.kept) kept_seen++;
      end
      results_checked++;
    end
  end

  // Abort when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------ sequence

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_cmd          <= '0;
    in_atom_slot    <= '0;
    in_pos_x        <= '0;
    in_pos_y        <= '0;
    in_pos_z        <= '0;
    in_func_id      <= '0;
    in_shell_kind   <= '0;
    in_owner_atom   <= '0;
    in_min_exponent <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    idle_on = 1'b1;
    settings_used = 1;

    // Register reset values
    cfg_ox = '0;
    cfg_oy = '0;
    cfg_oz = '0;
    cfg_len = cbfs_pkg::EDGE_RST;
    cfg_limit = cbfs_pkg::LIMIT_RST;
    cfg_keep = 1'b0;
    tally_s = '0;
    tally_p = '0;
    tally_d = '0;
    foreach (marks[i]) marks[i] = 1'b0;
    foreach (slot_known[i]) slot_known[i] = 1'b0;

    // Directed rows under the reset cube [0, 1.0] on each axis, limit 10.0
    directed_rows.push_back('{mk_atom(8'd0, 24'd0, 24'd0, 24'd0), 1'b1,
                              mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_atom(8'd255, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF),
                              1'b0, '0});
    directed_rows.push_back('{mk_atom(8'd1, 24'h800000, 24'h800000, 24'h800000),
                              1'b0, '0});
    // One unit outside on x
    directed_rows.push_back('{mk_atom(8'd2, 24'd8192, 24'd0, 24'd0), 1'b1,
                              mk_res(0, 0, 2, 0, 1 << 24, 0, 0, 0)});
    // On the far face: still inside
    directed_rows.push_back('{mk_atom(8'd3, 24'd4096, 24'd4096, 24'd4096), 1'b1,
                              mk_res(0, 0, 3, 0, 0, 0, 0, 0)});
    // One LSB out below x and above z
    directed_rows.push_back('{mk_atom(8'd4, 24'hFFFFFF, 24'd2048, 24'd4097), 1'b1,
                              mk_res(0, 0, 4, 0, 2, 0, 0, 0)});
    directed_rows.push_back('{mk_func(12'd0, cbfs_pkg::KIND_S, 8'd0, 32'd0), 1'b1,
                              mk_res(1, 0, 0, 1, 0, 1, 0, 0)});
    directed_rows.push_back('{mk_func(12'd4095, cbfs_pkg::KIND_P, 8'd0, 32'hFFFFFFFF),
                              1'b1, mk_res(1, 4095, 0, 0, 0, 1, 1, 0)});
    directed_rows.push_back('{mk_func(12'd5, cbfs_pkg::KIND_D, 8'd255, 32'hFFFFFFFF),
                              1'b0, '0});
    // Product equal to the threshold: dropped; exponent one lower: kept
    directed_rows.push_back('{mk_func(12'd6, cbfs_pkg::KIND_D, 8'd2, 32'd655360), 1'b1,
                              mk_res(0, 6, 2, 0, 1 << 24, 1, 1, 0)});
    directed_rows.push_back('{mk_func(12'd7, cbfs_pkg::KIND_D, 8'd2, 32'd655359), 1'b1,
                              mk_res(1, 7, 2, 1, 1 << 24, 1, 1, 1)});
    // Shell kind three is ignored but echoes its fields
    directed_rows.push_back('{mk_func(12'd8, cbfs_pkg::KIND_NONE, 8'd0, 32'd0), 1'b1,
                              mk_res(0, 8, 0, 0, 0, 1, 1, 1)});
    // Zero exponent keeps even the farthest nucleus
    directed_rows.push_back('{mk_func(12'd9, cbfs_pkg::KIND_S, 8'd1, 32'd0), 1'b0, '0});
    directed_rows.push_back('{mk_other(CMD_SPARE), 1'b1,
                              mk_res(0, 0, 0, 0, 0, 2, 1, 1)});
    directed_rows.push_back('{mk_other(cbfs_pkg::CMD_CLEAR), 1'b1,
                              mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_func(12'd10, cbfs_pkg::KIND_S, 8'd4, 32'hFFFFFFFF),
                              1'b0, '0});
    directed_rows.push_back('{mk_func(12'd11, cbfs_pkg::KIND_P, 8'd0, 32'd0), 1'b0, '0});
    directed_rows.push_back('{mk_atom(8'd0, 24'h123456, 24'hEDCBA9, 24'h000FFF),
                              1'b0, '0});
    directed_rows.push_back('{mk_func(12'd12, cbfs_pkg::KIND_D, 8'd0, 32'd1), 1'b0, '0});

    // Hold reset, then release it
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
    run_random(PHASE_ITEMS);

    // Lowest corner of x, highest of y, zero edge, nothing passes the screen
    program_cube('{24'h800000, 24'h7FFFFF, 24'h000000, 23'd0, 32'd0, 1'b0});
    idle_on = 1'b0;
    run_random(PHASE_ITEMS);
    idle_on = 1'b1;

    // Widest cube, largest limit, keep everything
    program_cube('{24'h7FFFFF, 24'h800000, 24'hFFF000, 23'h7FFFFF, 32'hFFFFFFFF, 1'b1});
    run_random(PHASE_ITEMS);

    repeat (3) begin
      program_cube(random_cube());
      run_random(PHASE_ITEMS);
    end

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("summary: %0d items sent, %0d result beats checked",
             items_sent, results_checked);
    $display("summary: %0d groups kept, %0d register writes over %0d cube settings",
             kept_seen, reg_writes, settings_used);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== cube_basis_function_screen_unit.f =====
design/cbfs_pkg.sv
design/cbfs_axis.sv
design/cbfs_dist_ram.sv
design/cbfs_screen.sv
design/cbfs_tally.sv
design/cube_basis_function_screen_unit.sv
bench/tb_top.sv
